// ===== rtl/efp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the escape-time fractal pixel block.
// Used by the top level, the controller, the datapath and the checker; no dependencies.
package efp_pkg;

    // Field widths of the request and result channels.
    localparam int PIX_W  = 9;
    localparam int CNT_W  = 8;
    localparam int GRAY_W = 8;

    // Fixed-point widths: c is 32-bit, z carries two guard bits above it.
    localparam int C_W = 32;
    localparam int Z_W = 34;
    localparam int M_W = 32;
    localparam int P_W = 64;

    // Reset value of the iteration limit register.
    localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd30;

    // The scale 2.2 / H is applied as 22 / (20 * H) on a doubled pixel offset.
    localparam int MAP_SCALE_NUM = 22;
    localparam int MAP_SCALE_DEN = 20;

    // Saturation bounds of c in the 32-bit signed range.
    localparam logic signed [P_W-1:0] C_MAX = (64'sd1 <<< (C_W - 1)) - 64'sd1;
    localparam logic signed [P_W-1:0] C_MIN = -(64'sd1 <<< (C_W - 1));

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // capture the pixel position
        logic map_re_start;  // form both bases and both remainder terms
        logic map_im_start;  // finish the real part of c
        logic map_finish;    // finish the imaginary part and clear the products
        logic update;        // z <- z*z + c from the registered products
        logic square;        // register the products of the current z
        logic count_inc;     // count one non-escaping update
        logic gray_start;    // start the gray scale division
        logic out_load;      // write the result register
    } t_efp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;
        logic limit_zero;
        logic out_of_bounds;
        logic escape;
        logic last;
        logic out_free;
    } t_efp_stat;

endpackage

// ===== rtl/escape_time_fractal_pixel.sv =====
`timescale 1ns / 1ps
// Top level of the escape-time fractal pixel block: controller plus datapath.
// Depends on efp_pkg, efp_ctrl, efp_datapath and efp_div.
//
//  Channel   Direction  Handshake                 Payload
//  ------------------------------------------------------------------------------
//  in        request    i_in_valid / o_in_stall   i_pixel_x, i_pixel_y
//  out       result     o_out_valid / i_out_stall o_iteration_count, o_gray_level
//  cfg       write      i_cfg_wr_en               i_cfg_wr_data (iteration limit)
//
// One pixel is worked on at a time. The time a request holds the block is set by the
// square-and-add loop, which alternates a square state and a check state, by the mapping
// states and by the bit-serial gray division; an escape or a bound check ends the loop early.
// Reset is synchronous and active low; it restores the limit to 30 and empties the result.
// A finished result waits in its register while the next request is already accepted.
module escape_time_fractal_pixel #(
    parameter int IMAGE_WIDTH   = 400,
    parameter int IMAGE_HEIGHT  = 300,
    parameter int FRACTION_BITS = 28
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [efp_pkg::CNT_W-1:0]  i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [efp_pkg::PIX_W-1:0]  i_pixel_x,
    input  logic [efp_pkg::PIX_W-1:0]  i_pixel_y,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [efp_pkg::CNT_W-1:0]  o_iteration_count,
    output logic [efp_pkg::GRAY_W-1:0] o_gray_level
);

    efp_pkg::t_efp_cmd  cmd;
    efp_pkg::t_efp_stat stat;

    // Sequencer.
    efp_ctrl u_efp_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Arithmetic and result register.
    efp_datapath #(
        .IMAGE_WIDTH   (IMAGE_WIDTH),
        .IMAGE_HEIGHT  (IMAGE_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_efp_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_pixel_x         (i_pixel_x),
        .i_pixel_y         (i_pixel_y),
        .i_out_stall       (i_out_stall),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_out_valid       (o_out_valid),
        .o_iteration_count (o_iteration_count),
        .o_gray_level      (o_gray_level)
    );

endmodule

// ===== rtl/efp_div.sv =====
`timescale 1ns / 1ps
// Restoring divider producing one quotient bit per cycle, used by the datapath for the gray scale.
// Self-contained; the caller preloads a partial remainder smaller than the divisor.
module efp_div #(
    parameter int DEN_W = 17,
    parameter int QUO_W = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [$clog2(QUO_W+1)-1:0] i_steps,
    input  logic [DEN_W-1:0]          i_rem,
    input  logic [QUO_W-1:0]          i_low,
    input  logic [DEN_W-1:0]          i_den,
    output logic                      o_busy,
    output logic [QUO_W-1:0]          o_quot
);

    localparam int SCW = $clog2(QUO_W + 1);

    logic [SCW-1:0]   r_steps;
    logic [SCW-1:0]   n_steps;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] n_rem;
    logic [QUO_W-1:0] r_low;
    logic [QUO_W-1:0] n_low;
    logic [QUO_W-1:0] r_quot;
    logic [QUO_W-1:0] n_quot;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] n_den;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;
    logic             fits;

    // One restoring step: shift in the next dividend bit and try the subtraction.
    always_comb begin
        shifted = {r_rem, r_low[QUO_W-1]};
        trial   = shifted - {1'b0, r_den};
        fits    = (shifted >= {1'b0, r_den});
        n_steps = r_steps;
        n_rem   = r_rem;
        n_low   = r_low;
        n_quot  = r_quot;
        n_den   = r_den;
        if (i_start) begin
            n_steps = i_steps;
            n_rem   = i_rem;
            n_low   = i_low;
            n_quot  = '0;
            n_den   = i_den;
        end else if (r_steps != '0) begin
            n_steps = r_steps - SCW'(1);
            n_rem   = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            n_low   = {r_low[QUO_W-2:0], 1'b0};
            n_quot  = {r_quot[QUO_W-2:0], fits};
        end
    end

    // Step counter is control state; the operands need no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
        end else begin
            r_steps <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_low  <= n_low;
        r_quot <= n_quot;
        r_den  <= n_den;
    end

    assign o_busy = (r_steps != '0);
    assign o_quot = r_quot;

endmodule

// ===== rtl/efp_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: coordinate mapping, the complex square-and-add loop, counting and gray scale.
// Depends on efp_pkg and instantiates efp_div.
module efp_datapath #(
    parameter int IMAGE_WIDTH   = 400,
    parameter int IMAGE_HEIGHT  = 300,
    parameter int FRACTION_BITS = 28
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [efp_pkg::CNT_W-1:0]       i_cfg_wr_data,
    input  logic [efp_pkg::PIX_W-1:0]       i_pixel_x,
    input  logic [efp_pkg::PIX_W-1:0]       i_pixel_y,
    input  logic                            i_out_stall,
    input  efp_pkg::t_efp_cmd               i_cmd,
    output efp_pkg::t_efp_stat              o_stat,
    output logic                            o_out_valid,
    output logic [efp_pkg::CNT_W-1:0]       o_iteration_count,
    output logic [efp_pkg::GRAY_W-1:0]      o_gray_level
);

    localparam int CNT_W  = efp_pkg::CNT_W;
    localparam int GRAY_W = efp_pkg::GRAY_W;
    localparam int Z_W    = efp_pkg::Z_W;
    localparam int C_W    = efp_pkg::C_W;
    localparam int M_W    = efp_pkg::M_W;
    localparam int P_W    = efp_pkg::P_W;

    // Upper bound on the offset magnitude |2*pixel - size| over all pixel codes and both axes.
    localparam int PIX_2MAX = 2 * ((1 << efp_pkg::PIX_W) - 1);
    localparam int SIZE_MAX = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam int SMAX     = (SIZE_MAX > PIX_2MAX) ? SIZE_MAX : PIX_2MAX;
    localparam int MW       = $clog2(SMAX + 1);
    localparam int SW       = MW + 1;

    // Mapping divisor and its split of the scale into quotient and remainder.
    localparam int DEN      = efp_pkg::MAP_SCALE_DEN * IMAGE_HEIGHT;
    localparam int DW       = $clog2(DEN + 1);
    localparam logic [63:0] MAP_NUM = 64'(efp_pkg::MAP_SCALE_NUM) << FRACTION_BITS;
    localparam logic [63:0] QC      = MAP_NUM / 64'(DEN);
    localparam logic [63:0] RC      = MAP_NUM % 64'(DEN);
    localparam int QCW      = $clog2(QC + 1);
    localparam int BW       = MW + QCW + 1;
    localparam int SUMW     = BW + 1;
    localparam int UW       = MW + DW;
    // Reciprocal of the mapping divisor, exact for every dividend below 2^UW.
    localparam int SH       = UW + DW;
    localparam int PRW      = 2 * UW + 2;
    localparam logic [63:0] RECIP   = (64'd1 << SH) / 64'(DEN) + 64'd1;
    localparam int SCW      = $clog2(GRAY_W + 1);
    localparam int GW       = CNT_W + GRAY_W;

    localparam logic signed [Z_W-1:0] Z_TWO   = Z_W'(64'sd2 <<< FRACTION_BITS);
    localparam logic signed [P_W-1:0] FOUR_SQ = 64'sd4 <<< (2 * FRACTION_BITS);

    logic [CNT_W-1:0]           r_limit;
    logic signed [SW-1:0]       r_s_re;
    logic signed [SW-1:0]       r_s_im;
    logic signed [BW-1:0]       r_base_re;
    logic signed [BW-1:0]       r_base_im;
    logic [UW-1:0]              r_u_re;
    logic [UW-1:0]              r_u_im;
    logic signed [C_W-1:0]      r_c_re;
    logic signed [C_W-1:0]      r_c_im;
    logic signed [Z_W-1:0]      r_z_re;
    logic signed [Z_W-1:0]      r_z_im;
    logic signed [P_W-1:0]      r_p_rr;
    logic signed [P_W-1:0]      r_p_ii;
    logic signed [P_W-1:0]      r_p_ri;
    logic [CNT_W-1:0]           r_count;
    logic                       r_out_valid;
    logic [CNT_W-1:0]           r_out_count;
    logic [GRAY_W-1:0]          r_out_gray;

    logic signed [SW-1:0]       n_s_re;
    logic signed [SW-1:0]       n_s_im;
    logic [MW-1:0]              mag_re;
    logic [MW-1:0]              mag_im;
    logic [UW-1:0]              n_u_re;
    logic [UW-1:0]              n_u_im;
    logic signed [BW-1:0]       qc_s;
    logic signed [BW-1:0]       n_base_re;
    logic signed [BW-1:0]       n_base_im;
    logic signed [BW-1:0]       fin_base;
    logic                       fin_neg;
    logic [UW-1:0]              fin_u;
    logic [PRW-1:0]             recip_prod;
    logic [MW:0]                term_mag;
    logic signed [MW+1:0]       term;
    logic signed [SUMW-1:0]     fin_sum;
    logic signed [P_W-1:0]      fin_sum64;
    logic signed [C_W-1:0]      fin_c;
    logic signed [P_W-1:0]      p_diff;
    logic signed [Z_W-1:0]      n_upd_re;
    logic signed [Z_W-1:0]      n_upd_im;
    logic signed [M_W-1:0]      re_m;
    logic signed [M_W-1:0]      im_m;
    logic signed [P_W-1:0]      n_p_rr;
    logic signed [P_W-1:0]      n_p_ii;
    logic signed [P_W-1:0]      n_p_ri;
    logic [GW-1:0]              gray_num;
    logic                       div_start;
    logic [SCW-1:0]             div_steps;
    logic [CNT_W-1:0]           div_rem_in;
    logic [GRAY_W-1:0]          div_low_in;
    logic [CNT_W-1:0]           div_den_in;
    logic                       div_busy;
    logic [GRAY_W-1:0]          div_quot;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= efp_pkg::LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    // Doubled pixel offsets from the image centre, their bases and remainder terms.
    // A negative offset gets the divisor less one added so that its quotient rounds up.
    always_comb begin
        n_s_re   = SW'({1'b0, i_pixel_x, 1'b0}) - SW'(IMAGE_WIDTH);
        n_s_im   = SW'({1'b0, i_pixel_y, 1'b0}) - SW'(IMAGE_HEIGHT);
        mag_re   = r_s_re[SW-1] ? MW'(-r_s_re) : MW'(r_s_re);
        mag_im   = r_s_im[SW-1] ? MW'(-r_s_im) : MW'(r_s_im);
        n_u_re   = UW'(mag_re) * UW'(RC) + (r_s_re[SW-1] ? UW'(DEN - 1) : UW'(0));
        n_u_im   = UW'(mag_im) * UW'(RC) + (r_s_im[SW-1] ? UW'(DEN - 1) : UW'(0));
        qc_s     = BW'(QC);
        n_base_re = BW'(r_s_re) * qc_s;
        n_base_im = BW'(r_s_im) * qc_s;
    end

    // Divide the remainder term by reciprocal multiplication, add the base, then saturate.
    always_comb begin
        fin_base   = i_cmd.map_finish ? r_base_im : r_base_re;
        fin_neg    = i_cmd.map_finish ? r_s_im[SW-1] : r_s_re[SW-1];
        fin_u      = i_cmd.map_finish ? r_u_im : r_u_re;
        recip_prod = PRW'(fin_u) * PRW'(RECIP);
        term_mag   = (MW+1)'(recip_prod >> SH);
        term       = fin_neg ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});
        fin_sum    = SUMW'(fin_base) + SUMW'(term);
        fin_sum64  = P_W'(fin_sum);
        if (fin_sum64 > efp_pkg::C_MAX) begin
            fin_c = C_W'(efp_pkg::C_MAX);
        end else if (fin_sum64 < efp_pkg::C_MIN) begin
            fin_c = C_W'(efp_pkg::C_MIN);
        end else begin
            fin_c = fin_sum64[C_W-1:0];
        end
    end

    // z update from the registered products, floored to the fraction width.
    always_comb begin
        p_diff   = r_p_rr - r_p_ii;
        n_upd_re = Z_W'(p_diff >>> FRACTION_BITS) + Z_W'(r_c_re);
        n_upd_im = Z_W'(r_p_ri >>> (FRACTION_BITS - 1)) + Z_W'(r_c_im);
    end

    // Squares of z; only taken while both parts are within the bounds.
    always_comb begin
        re_m   = r_z_re[M_W-1:0];
        im_m   = r_z_im[M_W-1:0];
        n_p_rr = re_m * re_m;
        n_p_ii = im_m * im_m;
        n_p_ri = re_m * im_m;
    end

    // Divider operands for the gray scale: 255 * count over the limit.
    always_comb begin
        gray_num   = {r_count, {GRAY_W{1'b0}}} - GW'(r_count);
        div_start  = i_cmd.gray_start;
        div_rem_in = gray_num[GW-1:GRAY_W];
        div_low_in = gray_num[GRAY_W-1:0];
        div_steps  = SCW'(GRAY_W);
        div_den_in = r_limit;
    end

    efp_div #(
        .DEN_W (CNT_W),
        .QUO_W (GRAY_W)
    ) u_efp_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_steps (div_steps),
        .i_rem   (div_rem_in),
        .i_low   (div_low_in),
        .i_den   (div_den_in),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // Working registers of one pixel.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s_re  <= n_s_re;
            r_s_im  <= n_s_im;
            r_count <= '0;
        end
        if (i_cmd.map_re_start) begin
            r_base_re <= n_base_re;
            r_base_im <= n_base_im;
            r_u_re    <= n_u_re;
            r_u_im    <= n_u_im;
        end
        if (i_cmd.map_im_start) begin
            r_c_re <= fin_c;
        end
        if (i_cmd.map_finish) begin
            r_c_im <= fin_c;
            r_p_rr <= '0;
            r_p_ii <= '0;
            r_p_ri <= '0;
        end
        if (i_cmd.square) begin
            r_p_rr <= n_p_rr;
            r_p_ii <= n_p_ii;
            r_p_ri <= n_p_ri;
        end
        if (i_cmd.update) begin
            r_z_re <= n_upd_re;
            r_z_im <= n_upd_im;
        end
        if (i_cmd.count_inc) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Result register: holds the finished pixel until the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_count <= r_count;
            r_out_gray  <= (r_limit == '0) ? '0 : div_quot;
        end
    end

    // Status towards the controller.
    always_comb begin
        o_stat.div_busy      = div_busy;
        o_stat.limit_zero    = (r_limit == '0);
        o_stat.out_of_bounds = (r_z_re > Z_TWO) || (r_z_re < -Z_TWO)
                            || (r_z_im > Z_TWO) || (r_z_im < -Z_TWO);
        o_stat.escape        = (r_p_rr + r_p_ii) > FOUR_SQ;
        o_stat.last          = (r_count + CNT_W'(1)) == r_limit;
        o_stat.out_free      = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid       = r_out_valid;
    assign o_iteration_count = r_out_count;
    assign o_gray_level      = r_out_gray;

endmodule

// ===== rtl/efp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine sequencing mapping, iteration and gray scale for one pixel.
// Depends on efp_pkg for the command and status structures.
module efp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  efp_pkg::t_efp_stat i_stat,
    output logic               o_in_stall,
    output efp_pkg::t_efp_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MAPRE  = 4'd1;
    localparam logic [3:0] S_WAITRE = 4'd2;
    localparam logic [3:0] S_WAITIM = 4'd3;
    localparam logic [3:0] S_UPD    = 4'd4;
    localparam logic [3:0] S_SQ     = 4'd5;
    localparam logic [3:0] S_CHK    = 4'd6;
    localparam logic [3:0] S_GRAY   = 4'd7;
    localparam logic [3:0] S_WAITG  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MAPRE;
                end
            end
            S_MAPRE: begin
                o_cmd.map_re_start = 1'b1;
                n_state            = S_WAITRE;
            end
            S_WAITRE: begin
                if (!i_stat.div_busy) begin
                    o_cmd.map_im_start = 1'b1;
                    n_state            = S_WAITIM;
                end
            end
            S_WAITIM: begin
                if (!i_stat.div_busy) begin
                    o_cmd.map_finish = 1'b1;
                    n_state          = i_stat.limit_zero ? S_GRAY : S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_SQ;
            end
            S_SQ: begin
                if (i_stat.out_of_bounds) begin
                    n_state = S_GRAY;
                end else begin
                    o_cmd.square = 1'b1;
                    n_state      = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.escape) begin
                    n_state = S_GRAY;
                end else begin
                    o_cmd.count_inc = 1'b1;
                    if (i_stat.last) begin
                        n_state = S_GRAY;
                    end else begin
                        o_cmd.update = 1'b1;
                        n_state      = S_SQ;
                    end
                end
            end
            S_GRAY: begin
                o_cmd.gray_start = 1'b1;
                n_state          = S_WAITG;
            end
            S_WAITG: begin
                if (!i_stat.div_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/efp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the escape-time fractal pixel block, bound to the top level.
// Depends on efp_pkg for field widths and the limit reset value.
module efp_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_cfg_wr_en,
    input logic [efp_pkg::CNT_W-1:0]  i_cfg_wr_data,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic [efp_pkg::PIX_W-1:0]  i_pixel_x,
    input logic [efp_pkg::PIX_W-1:0]  i_pixel_y,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [efp_pkg::CNT_W-1:0]  o_iteration_count,
    input logic [efp_pkg::GRAY_W-1:0] o_gray_level
);

    logic [efp_pkg::CNT_W-1:0] r_limit;

    // Shadow copy of the iteration limit as seen on the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= efp_pkg::LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    // A stalled result keeps its valid and its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_iteration_count)
                                       && $stable(o_gray_level))
        else $error("stalled result changed");

    // Only one pixel is in work: an accepted request blocks the next one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while a pixel was in work");

    // The count never passes the configured limit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_iteration_count <= r_limit)
        else $error("iteration count above the limit");

    // The gray level runs from black at no iterations to white at the limit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_iteration_count != '0) || (o_gray_level == '0))
                     && ((o_iteration_count != r_limit) || (r_limit == '0)
                         || (o_gray_level == '1)))
        else $error("gray level inconsistent with count");

endmodule

bind escape_time_fractal_pixel efp_checker u_efp_checker (.*);
